[hw/rtl/gnta_pkg.sv]
package gnta_pkg;

  localparam int BOT_W = 3;
  localparam int PIPE_DEPTH = 3;

  localparam logic OP_STORE  = 1'b0;
  localparam logic OP_TARGET = 1'b1;

  typedef struct packed {
    logic valid;
    logic found;
  } tok_t;

  function automatic int sq_w(int cb);
    return (cb + 1 > 32) ? 32 : cb + 1;
  endfunction

  function automatic int dist_w(int cb);
    return (2 * sq_w(cb) + 1 > 64) ? 64 : 2 * sq_w(cb) + 1;
  endfunction

endpackage

[hw/rtl/gnta_cell.sv]
module gnta_cell #(
  parameter int COORD_BITS = 16,
  parameter int IDX_W      = 3,
  parameter int CELL_IDX   = 0,
  parameter int DIST_W     = gnta_pkg::dist_w(COORD_BITS)
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         wr_en,
  input  logic signed [COORD_BITS-1:0] wr_x,
  input  logic signed [COORD_BITS-1:0] wr_y,
  input  logic signed [COORD_BITS-1:0] tgt_x,
  input  logic signed [COORD_BITS-1:0] tgt_y,
  input  logic                         clr_taken,
  input  logic                         set_taken,
  input  gnta_pkg::tok_t               tok_in,
  input  logic [IDX_W-1:0]             idx_in,
  input  logic [DIST_W-1:0]            dist_in,
  output gnta_pkg::tok_t               tok_out,
  output logic [IDX_W-1:0]             idx_out,
  output logic [DIST_W-1:0]            dist_out
);

  localparam int AW = COORD_BITS + 1;
  localparam int SW = gnta_pkg::sq_w(COORD_BITS);
  localparam logic [2*SW:0] DMAX_FULL = ~((2*SW+1)'(0)) >> (2*SW + 1 - DIST_W);
  localparam logic [DIST_W-1:0] DMAX = DMAX_FULL[DIST_W-1:0];

  logic signed [COORD_BITS-1:0] rx;
  logic signed [COORD_BITS-1:0] ry;
  logic                         taken;
  logic [AW-1:0]                adx;
  logic [AW-1:0]                ady;
  logic [2*SW-1:0]              sqx;
  logic [2*SW-1:0]              sqy;
  logic                         satx;
  logic                         saty;
  logic [DIST_W-1:0]            cur_dist;

  logic signed [AW-1:0] dx;
  logic signed [AW-1:0] dy;
  logic [SW-1:0]        opx;
  logic [SW-1:0]        opy;
  logic                 satx_c;
  logic                 saty_c;
  logic [2*SW:0]        sum_full;
  logic                 win;

  assign dx = $signed({rx[COORD_BITS-1], rx}) - $signed({tgt_x[COORD_BITS-1], tgt_x});
  assign dy = $signed({ry[COORD_BITS-1], ry}) - $signed({tgt_y[COORD_BITS-1], tgt_y});

  generate
    if (AW > SW) begin : g_sat
      assign satx_c = |adx[AW-1:SW];
      assign saty_c = |ady[AW-1:SW];
      assign opx    = adx[SW-1:0];
      assign opy    = ady[SW-1:0];
    end else begin : g_nosat
      assign satx_c = 1'b0;
      assign saty_c = 1'b0;
      assign opx    = adx;
      assign opy    = ady;
    end
  endgenerate

  assign sum_full = {1'b0, sqx} + {1'b0, sqy};

  assign win = tok_in.valid && !taken && (!tok_in.found || cur_dist < dist_in);

  always_ff @(posedge clk) begin
    if (rst) begin
      rx      <= '0;
      ry      <= '0;
      taken   <= 1'b0;
      tok_out <= '0;
    end else begin
      if (wr_en) begin
        rx <= wr_x;
        ry <= wr_y;
      end
      if (clr_taken) begin
        taken <= 1'b0;
      end else if (set_taken) begin
        taken <= 1'b1;
      end
      tok_out.valid <= tok_in.valid;
      tok_out.found <= tok_in.found | win;
    end
  end

  // distance pipeline: abs diff, square, sum
  always_ff @(posedge clk) begin
    adx  <= dx[AW-1] ? AW'(-dx) : AW'(dx);
    ady  <= dy[AW-1] ? AW'(-dy) : AW'(dy);
    sqx  <= (2*SW)'(opx) * (2*SW)'(opx);
    sqy  <= (2*SW)'(opy) * (2*SW)'(opy);
    satx <= satx_c;
    saty <= saty_c;
    cur_dist <= (satx || saty || sum_full > DMAX_FULL) ? DMAX : sum_full[DIST_W-1:0];
    idx_out  <= win ? IDX_W'(CELL_IDX) : idx_in;
    dist_out <= win ? cur_dist : dist_in;
  end

endmodule

[hw/rtl/greedy_nearest_target_assigner_core.sv]
// store transaction: accepted while idle, writes the robot's position, no result
// target transaction: result set by the three-stage distance pipeline in each cell, then
//   by the compare chain, one chain cell per cycle
// one target in flight; the next target is accepted only once the last result has been taken
// reset (synchronous): all positions zero, every robot free, no result pending
module greedy_nearest_target_assigner_core #(
  parameter int NUM_ROBOTS = 6,
  parameter int COORD_BITS = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           operation,
  input  logic [gnta_pkg::BOT_W-1:0]     bot_index,
  input  logic signed [COORD_BITS-1:0]   pos_x,
  input  logic signed [COORD_BITS-1:0]   pos_y,
  input  logic                           new_pattern,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [gnta_pkg::BOT_W-1:0]     assigned_bot,
  output logic signed [COORD_BITS-1:0]   target_x,
  output logic signed [COORD_BITS-1:0]   target_y,
  output logic                           no_free_bot
);

  localparam int IDX_W = $clog2(NUM_ROBOTS);
  localparam int DW    = gnta_pkg::dist_w(COORD_BITS);
  localparam int CW    = $clog2(gnta_pkg::PIPE_DEPTH + 1);
  localparam int BW    = gnta_pkg::BOT_W;

  typedef enum logic [1:0] {S_IDLE, S_WAIT, S_CHAIN} state_t;

  state_t                       state;
  logic [CW-1:0]                wcnt;
  logic signed [COORD_BITS-1:0] tgt_x;
  logic signed [COORD_BITS-1:0] tgt_y;

  gnta_pkg::tok_t  tok  [NUM_ROBOTS+1];
  logic [IDX_W-1:0] idx [NUM_ROBOTS+1];
  logic [DW-1:0]   chain_dist [NUM_ROBOTS+1];
  logic [NUM_ROBOTS-1:0] mark;
  logic [NUM_ROBOTS-1:0] chain_valid;

  logic               in_acc;
  logic               start;
  logic               done;
  logic               clr;
  logic [BW+IDX_W-1:0] win_ext;

  assign in_ready = (state == S_IDLE) && (operation == gnta_pkg::OP_STORE || !out_valid);
  assign in_acc   = in_valid && in_ready;
  assign clr      = in_acc && operation == gnta_pkg::OP_TARGET && new_pattern;
  assign start    = (state == S_WAIT) && wcnt == CW'(gnta_pkg::PIPE_DEPTH);
  assign done     = (state == S_CHAIN) && tok[NUM_ROBOTS].valid;
  assign win_ext  = {BW'(0), idx[NUM_ROBOTS]};

  assign tok[0].valid  = start;
  assign tok[0].found  = 1'b0;
  assign idx[0]        = '0;
  assign chain_dist[0] = '0;

  generate
    for (genvar g = 0; g < NUM_ROBOTS; g++) begin : g_cell
      assign mark[g]        = done && tok[NUM_ROBOTS].found && idx[NUM_ROBOTS] == IDX_W'(g);
      assign chain_valid[g] = tok[g+1].valid;

      gnta_cell #(
        .COORD_BITS(COORD_BITS),
        .IDX_W     (IDX_W),
        .CELL_IDX  (g),
        .DIST_W    (DW)
      ) u_cell (
        .clk      (clk),
        .rst      (rst),
        .wr_en    (in_acc && operation == gnta_pkg::OP_STORE && 32'(bot_index) == g),
        .wr_x     (pos_x),
        .wr_y     (pos_y),
        .tgt_x    (tgt_x),
        .tgt_y    (tgt_y),
        .clr_taken(clr),
        .set_taken(mark[g]),
        .tok_in   (tok[g]),
        .idx_in   (idx[g]),
        .dist_in  (chain_dist[g]),
        .tok_out  (tok[g+1]),
        .idx_out  (idx[g+1]),
        .dist_out (chain_dist[g+1])
      );
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      wcnt      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_acc && operation == gnta_pkg::OP_TARGET) begin
            state <= S_WAIT;
            wcnt  <= '0;
            tgt_x <= pos_x;
            tgt_y <= pos_y;
          end
        end
        S_WAIT: begin
          if (start) begin
            state <= S_CHAIN;
          end else begin
            wcnt <= wcnt + CW'(1);
          end
        end
        S_CHAIN: begin
          if (done) begin
            state        <= S_IDLE;
            out_valid    <= 1'b1;
            assigned_bot <= tok[NUM_ROBOTS].found ? win_ext[BW-1:0] : BW'(0);
            no_free_bot  <= !tok[NUM_ROBOTS].found;
            target_x     <= tgt_x;
            target_y     <= tgt_y;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTH
  a_done_slot_free: assert property (@(posedge clk) disable iff (rst)
    done |-> !out_valid)
    else $error("result ready while output slot is full");

  a_mark_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot0(mark))
    else $error("more than one robot marked taken");

  a_single_token: assert property (@(posedge clk) disable iff (rst)
    $onehot0(chain_valid))
    else $error("more than one compare token in the chain");

  a_busy_after_target: assert property (@(posedge clk) disable iff (rst)
    (in_acc && operation == gnta_pkg::OP_TARGET) |=> (!in_ready && state == S_WAIT))
    else $error("target transaction did not start the distance pipeline");
`endif

endmodule
